// ----- rtl/core/cpmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Cascaded position regulator package
// Shared constants, register indexes, configuration and microcode types.
// ----------------------------------------------------------------------------
package cpmr_pkg;

    localparam int unsigned MAX_STEP = 65535;
    localparam int unsigned PWM_MAX  = 255;
    localparam int unsigned PWM_CAP  = (PWM_MAX > 255) ? 255 : PWM_MAX;

    localparam int unsigned ACC_W = 58;
    localparam int unsigned ERR_W = 33;

    localparam logic MODE_EDGE = 1'b0;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_POSITION_GAIN        = 3'd0;
    localparam reg_index_t REG_INTEGRAL_GAIN_PERIOD = 3'd1;
    localparam reg_index_t REG_INTEGRAL_LIMIT       = 3'd2;
    localparam reg_index_t REG_DRIVE_GAIN           = 3'd3;
    localparam reg_index_t REG_DEVIATION            = 3'd4;
    localparam reg_index_t REG_TARGET               = 3'd5;
    localparam reg_index_t REG_STEP_LIMIT           = 3'd6;

    typedef struct packed {
        logic [15:0]        position_gain;
        logic [23:0]        integral_gain_period;
        logic [15:0]        integral_limit;
        logic [15:0]        drive_gain;
        logic [15:0]        deviation;
        logic signed [31:0] target;
        logic [15:0]        step_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_BRANCH_EDGE,
        UOP_COUNT,
        UOP_ERR_TARGET,
        UOP_ERR_SETPOINT,
        UOP_MUL,
        UOP_TRUNC,
        UOP_ADD_INTEGRAL,
        UOP_CLAMP,
        UOP_STORE_INTEGRAL,
        UOP_ADD_SETPOINT,
        UOP_PWM,
        UOP_REPORT
    } uop_t;

    typedef enum logic [1:0] {
        SEL_INTEGRAL,
        SEL_POSITION,
        SEL_DRIVE
    } sel_t;

    typedef logic [4:0] upc_t;

    localparam upc_t EDGE_ENTRY = 5'd17;

    typedef struct packed {
        uop_t op;
        sel_t sel;
        upc_t jump;
    } ucode_t;

    typedef struct packed {
        uop_t op;
        sel_t sel;
        logic phase_b;
    } dp_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t w;
        w = '{op: UOP_NOP, sel: SEL_INTEGRAL, jump: '0};
        unique case (pc)
            5'd0:  w = '{op: UOP_BRANCH_EDGE,    sel: SEL_INTEGRAL, jump: EDGE_ENTRY};
            5'd1:  w = '{op: UOP_ERR_TARGET,     sel: SEL_INTEGRAL, jump: '0};
            5'd2:  w = '{op: UOP_MUL,            sel: SEL_INTEGRAL, jump: '0};
            5'd3:  w = '{op: UOP_TRUNC,          sel: SEL_INTEGRAL, jump: '0};
            5'd4:  w = '{op: UOP_ADD_INTEGRAL,   sel: SEL_INTEGRAL, jump: '0};
            5'd5:  w = '{op: UOP_CLAMP,          sel: SEL_INTEGRAL, jump: '0};
            5'd6:  w = '{op: UOP_STORE_INTEGRAL, sel: SEL_INTEGRAL, jump: '0};
            5'd7:  w = '{op: UOP_MUL,            sel: SEL_POSITION, jump: '0};
            5'd8:  w = '{op: UOP_ADD_INTEGRAL,   sel: SEL_POSITION, jump: '0};
            5'd9:  w = '{op: UOP_TRUNC,          sel: SEL_POSITION, jump: '0};
            5'd10: w = '{op: UOP_CLAMP,          sel: SEL_POSITION, jump: '0};
            5'd11: w = '{op: UOP_ADD_SETPOINT,   sel: SEL_POSITION, jump: '0};
            5'd12: w = '{op: UOP_ERR_SETPOINT,   sel: SEL_DRIVE,    jump: '0};
            5'd13: w = '{op: UOP_MUL,            sel: SEL_DRIVE,    jump: '0};
            5'd14: w = '{op: UOP_TRUNC,          sel: SEL_DRIVE,    jump: '0};
            5'd15: w = '{op: UOP_PWM,            sel: SEL_DRIVE,    jump: '0};
            5'd16: w = '{op: UOP_REPORT,         sel: SEL_DRIVE,    jump: '0};
            5'd17: w = '{op: UOP_COUNT,          sel: SEL_INTEGRAL, jump: '0};
            5'd18: w = '{op: UOP_REPORT,         sel: SEL_INTEGRAL, jump: '0};
            default: w = '{op: UOP_REPORT, sel: SEL_INTEGRAL, jump: '0};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/cpmr_if.sv -----
// ----------------------------------------------------------------------------
// Cascaded position regulator channels
// Valid/ready interfaces for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface cpmr_item_if;
    logic valid;
    logic ready;
    logic mode;
    logic phase_b;

    modport source (output valid, output mode, output phase_b, input ready);
    modport sink (input valid, input mode, input phase_b, output ready);
endinterface

interface cpmr_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         drive_a;
    logic [7:0]         drive_b;
    logic               at_target;
    logic signed [31:0] position;

    modport source (output valid, output drive_a, output drive_b, output at_target,
                    output position, input ready);
    modport sink (input valid, input drive_a, input drive_b, input at_target,
                  input position, output ready);
endinterface

interface cpmr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/cpmr_datapath.sv -----
// ----------------------------------------------------------------------------
// Cascaded position regulator datapath
// Shared multiplier, accumulator and regulator state driven by microcode.
// ----------------------------------------------------------------------------
module cpmr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cpmr_pkg::dp_ctrl_t  ctrl,
    input  cpmr_pkg::cfg_t      cfg,
    output logic signed [31:0]  position,
    output logic [7:0]          drive_fwd,
    output logic [7:0]          drive_rev,
    output logic                at_target
);

    localparam int unsigned AW = cpmr_pkg::ACC_W;
    localparam int unsigned EW = cpmr_pkg::ERR_W;
    localparam logic signed [AW-1:0] CAP = AW'(cpmr_pkg::PWM_CAP);
    localparam logic signed [AW-1:0] RND = AW'(255);

    logic signed [31:0]   pos_reg, pos_next;
    logic signed [31:0]   integ_reg, integ_next;
    logic signed [31:0]   sp_reg, sp_next;
    logic [7:0]           fwd_reg, fwd_next;
    logic [7:0]           rev_reg, rev_next;
    logic signed [EW-1:0] e_reg, e_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    logic [23:0]          gain;
    logic [15:0]          step;
    logic signed [AW-1:0] lim;
    logic signed [AW-1:0] neg_lim;
    logic signed [AW-1:0] rounded;
    logic signed [AW-1:0] neg_acc;
    logic signed [EW-1:0] tgt_err;
    logic signed [EW-1:0] dev;

    always_comb
    begin
        step = (cfg.step_limit == 16'd0) ? 16'd1 : cfg.step_limit;
        if (step > 16'(cpmr_pkg::MAX_STEP))
        begin
            step = 16'(cpmr_pkg::MAX_STEP);
        end

        unique case (ctrl.sel)
            cpmr_pkg::SEL_INTEGRAL: gain = cfg.integral_gain_period;
            cpmr_pkg::SEL_POSITION: gain = {8'd0, cfg.position_gain};
            cpmr_pkg::SEL_DRIVE:    gain = {8'd0, cfg.drive_gain};
            default:                gain = '0;
        endcase

        if (ctrl.sel == cpmr_pkg::SEL_INTEGRAL)
        begin
            lim = AW'({cfg.integral_limit, 8'd0});
        end
        else
        begin
            lim = AW'(step);
        end
        neg_lim = -lim;
        rounded = acc_reg + (acc_reg[AW-1] ? RND : '0);
        neg_acc = -acc_reg;

        pos_next   = pos_reg;
        integ_next = integ_reg;
        sp_next    = sp_reg;
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;

        unique case (ctrl.op)
            cpmr_pkg::UOP_COUNT:
            begin
                pos_next = ctrl.phase_b ? pos_reg + 32'sd1 : pos_reg - 32'sd1;
            end
            cpmr_pkg::UOP_ERR_TARGET:
            begin
                e_next = {cfg.target[31], cfg.target} - {pos_reg[31], pos_reg};
            end
            cpmr_pkg::UOP_ERR_SETPOINT:
            begin
                e_next = {sp_reg[31], sp_reg} - {pos_reg[31], pos_reg};
            end
            cpmr_pkg::UOP_MUL:
            begin
                acc_next = e_reg * $signed({1'b0, gain});
            end
            cpmr_pkg::UOP_TRUNC:
            begin
                acc_next = rounded >>> 8;
            end
            cpmr_pkg::UOP_ADD_INTEGRAL:
            begin
                acc_next = acc_reg + AW'(integ_reg);
            end
            cpmr_pkg::UOP_CLAMP:
            begin
                if (acc_reg > lim)
                begin
                    acc_next = lim;
                end
                else if (acc_reg < neg_lim)
                begin
                    acc_next = neg_lim;
                end
            end
            cpmr_pkg::UOP_STORE_INTEGRAL:
            begin
                integ_next = acc_reg[31:0];
            end
            cpmr_pkg::UOP_ADD_SETPOINT:
            begin
                sp_next = sp_reg + acc_reg[31:0];
            end
            cpmr_pkg::UOP_PWM:
            begin
                fwd_next = 8'd0;
                rev_next = 8'd0;
                if (acc_reg > CAP)
                begin
                    fwd_next = CAP[7:0];
                end
                else if (acc_reg > 0)
                begin
                    fwd_next = acc_reg[7:0];
                end
                else if (neg_acc > CAP)
                begin
                    rev_next = CAP[7:0];
                end
                else
                begin
                    rev_next = neg_acc[7:0];
                end
            end
            default:
            begin
            end
        endcase

        tgt_err = {cfg.target[31], cfg.target} - {pos_reg[31], pos_reg};
        dev     = EW'(cfg.deviation);
        at_target = (tgt_err <= dev) && (tgt_err >= -dev);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            integ_reg <= '0;
            sp_reg    <= '0;
            fwd_reg   <= '0;
            rev_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            integ_reg <= integ_next;
            sp_reg    <= sp_next;
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        acc_reg <= acc_next;
    end

    assign position  = pos_reg;
    assign drive_fwd = fwd_reg;
    assign drive_rev = rev_reg;

endmodule

// ----- rtl/core/cascaded_position_motor_regulator.sv -----
// ----------------------------------------------------------------------------
// Cascaded position motor regulator
// Encoder counter, PI setpoint regulator and H-bridge PWM split.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries mode (0 encoder rising edge, 1 control tick) and
// phase_b. Every item yields exactly one result transfer with both PWM
// duties, the at-target flag and the current encoder count.
// The cfg channel is always ready; a transfer writes the register at index
// (0 position gain to 6 step limit); higher indexes are ignored. Write it only
// while the block is idle.
// An item is taken only while the sequencer is idle. An encoder edge runs
// three microcode steps and a control tick runs seventeen, one step per cycle
// through the shared multiplier and accumulator while the final step is not
// held by a stalled receiver.
// The result sits in an output register; a stalled receiver holds it, and
// the sequencer then waits on its final step until the register is free.
// Reset loads the register defaults and clears count, integral, setpoint,
// and both drive outputs.
// ----------------------------------------------------------------------------
module cascaded_position_motor_regulator (
    input  logic         clk,
    input  logic         rst_n,
    cpmr_item_if.sink    item,
    cpmr_result_if.source result,
    cpmr_cfg_if.sink     cfg
);

    cpmr_pkg::cfg_t     cfg_reg;
    cpmr_pkg::state_t   state_reg, state_next;
    cpmr_pkg::upc_t     pc_reg, pc_next;
    cpmr_pkg::ucode_t   uc;
    cpmr_pkg::dp_ctrl_t dp_ctrl;

    logic               mode_reg;
    logic               phase_b_reg;
    logic               load_out;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         drive_a_reg;
    logic [7:0]         drive_b_reg;
    logic               at_target_reg;
    logic signed [31:0] position_reg;

    logic signed [31:0] dp_position;
    logic [7:0]         dp_fwd;
    logic [7:0]         dp_rev;
    logic               dp_at_target;

    assign uc = cpmr_pkg::ucode_rom(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_gain        <= 16'd256;
            cfg_reg.integral_gain_period <= 24'd0;
            cfg_reg.integral_limit       <= 16'd100;
            cfg_reg.drive_gain           <= 16'd256;
            cfg_reg.deviation            <= 16'd2;
            cfg_reg.target               <= 32'sd0;
            cfg_reg.step_limit           <= 16'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cpmr_pkg::REG_POSITION_GAIN:        cfg_reg.position_gain <= cfg.data[15:0];
                cpmr_pkg::REG_INTEGRAL_GAIN_PERIOD:
                    cfg_reg.integral_gain_period <= cfg.data[23:0];
                cpmr_pkg::REG_INTEGRAL_LIMIT:       cfg_reg.integral_limit <= cfg.data[15:0];
                cpmr_pkg::REG_DRIVE_GAIN:           cfg_reg.drive_gain <= cfg.data[15:0];
                cpmr_pkg::REG_DEVIATION:            cfg_reg.deviation <= cfg.data[15:0];
                cpmr_pkg::REG_TARGET:               cfg_reg.target <= cfg.data;
                cpmr_pkg::REG_STEP_LIMIT:           cfg_reg.step_limit <= cfg.data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == cpmr_pkg::ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        load_out        = 1'b0;
        dp_ctrl.op      = cpmr_pkg::UOP_NOP;
        dp_ctrl.sel     = uc.sel;
        dp_ctrl.phase_b = phase_b_reg;

        unique case (state_reg)
            cpmr_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = cpmr_pkg::ST_RUN;
                    pc_next    = '0;
                end
            end
            cpmr_pkg::ST_RUN:
            begin
                dp_ctrl.op = uc.op;
                if (uc.op == cpmr_pkg::UOP_REPORT)
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        load_out   = 1'b1;
                        state_next = cpmr_pkg::ST_IDLE;
                    end
                end
                else if (uc.op == cpmr_pkg::UOP_BRANCH_EDGE && mode_reg == cpmr_pkg::MODE_EDGE)
                begin
                    pc_next = uc.jump;
                end
                else
                begin
                    pc_next = pc_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = cpmr_pkg::ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpmr_pkg::ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            mode_reg    <= item.mode;
            phase_b_reg <= item.phase_b;
        end
        if (load_out)
        begin
            drive_a_reg   <= dp_fwd;
            drive_b_reg   <= dp_rev;
            at_target_reg <= dp_at_target;
            position_reg  <= dp_position;
        end
    end

    cpmr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .cfg       (cfg_reg),
        .position  (dp_position),
        .drive_fwd (dp_fwd),
        .drive_rev (dp_rev),
        .at_target (dp_at_target)
    );

    assign result.valid     = out_valid_reg;
    assign result.drive_a   = drive_a_reg;
    assign result.drive_b   = drive_b_reg;
    assign result.at_target = at_target_reg;
    assign result.position  = position_reg;

endmodule
